// File: hw/rtl/seca_pkg.sv
// Shared types, codes and helpers for the shutter edge capture analyzer.
package seca_pkg;

    localparam int TIME_BITS = 32;
    localparam int NCH       = 5;
    localparam int OUT_BITS  = 32;
    localparam int CFG_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ARMED = 2'd1;
    localparam logic [1:0] PH_BUSY  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_CENTRAL = 2'd1;
    localparam logic [1:0] KIND_HORIZ   = 2'd2;
    localparam logic [1:0] KIND_VERT    = 2'd3;

    localparam logic [2:0] CH_TL = 3'd0;
    localparam logic [2:0] CH_BL = 3'd1;
    localparam logic [2:0] CH_C  = 3'd2;
    localparam logic [2:0] CH_TR = 3'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW  = CFG_IDX_BITS'(1);

    localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;
    localparam logic [15:0] WINDOW_RESET  = 16'd200;

    typedef logic [TIME_BITS-1:0] time_t;

    // Stored capture as seen by the analysis logic
    typedef struct packed {
        logic [1:0]                     phase;
        logic [NCH-1:0]                 done;
        logic [NCH-1:0][TIME_BITS-1:0]  rise;
        logic [NCH-1:0][TIME_BITS-1:0]  fall;
    } capture_t;

    typedef struct packed {
        logic [1:0]          capture_state;
        logic                all_channels_valid;
        logic [1:0]          shutter_kind;
        logic [OUT_BITS-1:0] center_duration_us;
        logic [OUT_BITS-1:0] first_curtain_travel_us;
        logic [OUT_BITS-1:0] second_curtain_travel_us;
        logic [OUT_BITS-1:0] first_curtain_skew_us;
        logic [OUT_BITS-1:0] second_curtain_skew_us;
        logic [OUT_BITS-1:0] reference_exposure_us;
        logic [OUT_BITS-1:0] compared_exposure_us;
    } result_t;

    // Magnitude of a wrapped time difference
    function automatic time_t tabs(input time_t a, input time_t b);
        time_t d;
        d = a - b;
        return d[TIME_BITS-1] ? (~d + time_t'(1)) : d;
    endfunction

endpackage

// File: hw/rtl/shutter_edge_capture_analyzer.sv
// Top level of the shutter edge capture analyzer: handshake, config and result register.
//
// Every accepted transaction (arm, sensor edge, tick or stop) updates the capture
// state at its accept edge and yields exactly one result: the stored capture is
// then analyzed and loads the result register once the output is free, and the
// result is offered on m_valid from the cycle after that load. One transaction per
// cycle is sustained as long as results are taken; a stalled output holds at most
// one analyzed and one pending transaction before s_ready drops. Configuration
// writes take effect at once and should be issued only while no transaction is in
// flight.
module shutter_edge_capture_analyzer (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [seca_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [seca_pkg::CFG_BITS-1:0]     cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic [2:0]                        s_channel,
    input  logic                              s_level,
    input  logic [31:0]                       s_now_us,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_capture_state,
    output logic                              m_all_channels_valid,
    output logic [1:0]                        m_shutter_kind,
    output logic [31:0]                       m_center_duration_us,
    output logic [31:0]                       m_first_curtain_travel_us,
    output logic [31:0]                       m_second_curtain_travel_us,
    output logic signed [31:0]                m_first_curtain_skew_us,
    output logic signed [31:0]                m_second_curtain_skew_us,
    output logic [31:0]                       m_reference_exposure_us,
    output logic [31:0]                       m_compared_exposure_us
);

    logic [31:0]        timeout_reg;
    logic [15:0]        window_reg;
    logic               pend_reg;
    logic               out_valid_reg;
    seca_pkg::result_t  res_reg;
    seca_pkg::result_t  res_next;
    seca_pkg::capture_t cap;
    logic               in_en;
    logic               load;

    // state holds an unanalyzed transaction while pend_reg is set
    assign load    = pend_reg && (!out_valid_reg || m_ready);
    assign s_ready = !pend_reg || load;
    assign in_en   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= seca_pkg::TIMEOUT_RESET;
            window_reg  <= seca_pkg::WINDOW_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                seca_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata[31:0];
                seca_pkg::REG_WINDOW:  window_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    seca_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_en      (in_en),
        .opcode     (s_opcode),
        .channel    (s_channel),
        .level      (s_level),
        .now_us     (s_now_us),
        .timeout_us (timeout_reg),
        .cap        (cap)
    );

    seca_analyze u_analyze (
        .cap               (cap),
        .central_window_us (window_reg),
        .res               (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_en) begin
                pend_reg <= 1'b1;
            end else if (load) begin
                pend_reg <= 1'b0;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid                    = out_valid_reg;
    assign m_capture_state            = res_reg.capture_state;
    assign m_all_channels_valid       = res_reg.all_channels_valid;
    assign m_shutter_kind             = res_reg.shutter_kind;
    assign m_center_duration_us       = res_reg.center_duration_us;
    assign m_first_curtain_travel_us  = res_reg.first_curtain_travel_us;
    assign m_second_curtain_travel_us = res_reg.second_curtain_travel_us;
    assign m_first_curtain_skew_us    = signed'(res_reg.first_curtain_skew_us);
    assign m_second_curtain_skew_us   = signed'(res_reg.second_curtain_skew_us);
    assign m_reference_exposure_us    = res_reg.reference_exposure_us;
    assign m_compared_exposure_us     = res_reg.compared_exposure_us;

endmodule

// File: hw/rtl/seca_capture.sv
// Capture state: phase, per-channel rise/fall times and flags.
module seca_capture (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_en,
    input  logic [1:0]                 opcode,
    input  logic [2:0]                 channel,
    input  logic                       level,
    input  logic [31:0]                now_us,
    input  logic [31:0]                timeout_us,
    output seca_pkg::capture_t         cap
);

    logic [1:0]                                      phase_reg, phase_next;
    seca_pkg::time_t                                 start_reg, start_next;
    logic [seca_pkg::NCH-1:0]                        seen_reg, seen_next;
    logic [seca_pkg::NCH-1:0]                        done_reg, done_next;
    logic [seca_pkg::NCH-1:0][seca_pkg::TIME_BITS-1:0] rise_reg, rise_next;
    logic [seca_pkg::NCH-1:0][seca_pkg::TIME_BITS-1:0] fall_reg, fall_next;
    seca_pkg::time_t                                 now_t;
    seca_pkg::time_t                                 busy_time;
    logic [1:0]                                      ph;
    logic                                            ch_ok;

    assign now_t     = seca_pkg::time_t'(now_us);
    assign busy_time = now_t - start_reg;
    assign ch_ok     = (channel < 3'(seca_pkg::NCH));

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        done_next  = done_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        ph         = phase_reg;
        case (opcode)
            seca_pkg::OP_ARM: begin
                // times need no clearing: they are read only behind the flags
                phase_next = seca_pkg::PH_ARMED;
                seen_next  = '0;
                done_next  = '0;
            end
            seca_pkg::OP_EDGE: begin
                if (ch_ok) begin
                    if (phase_reg == seca_pkg::PH_ARMED && level) begin
                        ph         = seca_pkg::PH_BUSY;
                        start_next = now_t;
                    end
                    phase_next = ph;
                    if (ph == seca_pkg::PH_BUSY) begin
                        if (level) begin
                            if (!seen_reg[channel]) begin
                                seen_next[channel] = 1'b1;
                                rise_next[channel] = now_t;
                            end
                        end else if (seen_reg[channel] && !done_reg[channel]) begin
                            fall_next[channel] = now_t;
                            done_next[channel] = 1'b1;
                            if (&done_next) begin
                                phase_next = seca_pkg::PH_DONE;
                            end
                        end
                    end
                end
            end
            seca_pkg::OP_TICK: begin
                if (phase_reg == seca_pkg::PH_BUSY &&
                    {32'd0, busy_time} > {seca_pkg::TIME_BITS'(0), timeout_us}) begin
                    phase_next = seca_pkg::PH_DONE;
                end
            end
            default: begin
                phase_next = seca_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= seca_pkg::PH_IDLE;
            seen_reg  <= '0;
            done_reg  <= '0;
        end else if (in_en) begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en) begin
            start_reg <= start_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
        end
    end

    assign cap.phase = phase_reg;
    assign cap.done  = done_reg;
    assign cap.rise  = rise_reg;
    assign cap.fall  = fall_reg;

endmodule

// File: hw/rtl/seca_analyze.sv
// Shutter analysis of the stored capture: kind, travel, skew, exposures.
module seca_analyze (
    input  seca_pkg::capture_t  cap,
    input  logic [15:0]         central_window_us,
    output seca_pkg::result_t   res
);

    seca_pkg::time_t dh, dv;
    seca_pkg::time_t fh, fv;
    seca_pkg::time_t skew_rh, skew_rv, skew_fh, skew_fv;
    seca_pkg::time_t exp_c, exp_tl, exp_bl, exp_tr;
    logic            all_done;
    logic            central;
    logic            horiz;

    assign all_done = &cap.done;

    assign dh = seca_pkg::tabs(cap.rise[seca_pkg::CH_TR], cap.rise[seca_pkg::CH_TL]);
    assign dv = seca_pkg::tabs(cap.rise[seca_pkg::CH_BL], cap.rise[seca_pkg::CH_TL]);
    assign fh = seca_pkg::tabs(cap.fall[seca_pkg::CH_TR], cap.fall[seca_pkg::CH_TL]);
    assign fv = seca_pkg::tabs(cap.fall[seca_pkg::CH_BL], cap.fall[seca_pkg::CH_TL]);

    // skew is taken on the cross axis: bottom left for horizontal, top right for vertical
    assign skew_rh = cap.rise[seca_pkg::CH_BL] - cap.rise[seca_pkg::CH_TL];
    assign skew_fh = cap.fall[seca_pkg::CH_BL] - cap.fall[seca_pkg::CH_TL];
    assign skew_rv = cap.rise[seca_pkg::CH_TR] - cap.rise[seca_pkg::CH_TL];
    assign skew_fv = cap.fall[seca_pkg::CH_TR] - cap.fall[seca_pkg::CH_TL];

    assign exp_c  = cap.fall[seca_pkg::CH_C]  - cap.rise[seca_pkg::CH_C];
    assign exp_tl = cap.fall[seca_pkg::CH_TL] - cap.rise[seca_pkg::CH_TL];
    assign exp_bl = cap.fall[seca_pkg::CH_BL] - cap.rise[seca_pkg::CH_BL];
    assign exp_tr = cap.fall[seca_pkg::CH_TR] - cap.rise[seca_pkg::CH_TR];

    assign central = ({16'd0, dh} < {seca_pkg::TIME_BITS'(0), central_window_us}) &&
                     ({16'd0, dv} < {seca_pkg::TIME_BITS'(0), central_window_us});
    assign horiz   = (dh >= dv);

    always_comb begin
        res = '0;
        res.capture_state      = cap.phase;
        res.all_channels_valid = all_done;
        if (cap.done[seca_pkg::CH_C]) begin
            res.center_duration_us = seca_pkg::OUT_BITS'(exp_c);
        end
        if (all_done) begin
            if (central) begin
                res.shutter_kind          = seca_pkg::KIND_CENTRAL;
                res.reference_exposure_us = seca_pkg::OUT_BITS'(exp_c);
                res.compared_exposure_us  = seca_pkg::OUT_BITS'(exp_tl);
            end else if (horiz) begin
                res.shutter_kind             = seca_pkg::KIND_HORIZ;
                res.first_curtain_travel_us  = seca_pkg::OUT_BITS'(dh);
                res.second_curtain_travel_us = seca_pkg::OUT_BITS'(fh);
                res.first_curtain_skew_us    = seca_pkg::OUT_BITS'(signed'(skew_rh));
                res.second_curtain_skew_us   = seca_pkg::OUT_BITS'(signed'(skew_fh));
                res.reference_exposure_us    = seca_pkg::OUT_BITS'(exp_tl);
                res.compared_exposure_us     = seca_pkg::OUT_BITS'(exp_bl);
            end else begin
                res.shutter_kind             = seca_pkg::KIND_VERT;
                res.first_curtain_travel_us  = seca_pkg::OUT_BITS'(dv);
                res.second_curtain_travel_us = seca_pkg::OUT_BITS'(fv);
                res.first_curtain_skew_us    = seca_pkg::OUT_BITS'(signed'(skew_rv));
                res.second_curtain_skew_us   = seca_pkg::OUT_BITS'(signed'(skew_fv));
                res.reference_exposure_us    = seca_pkg::OUT_BITS'(exp_tl);
                res.compared_exposure_us     = seca_pkg::OUT_BITS'(exp_tr);
            end
        end
    end

endmodule
